FILE: design/kwm_pkg.sv
// shared types and constants for the k-way sorted merge engine
`timescale 1ns / 1ps

package kwm_pkg;

	// default geometry
	localparam int WAYS_DEF  = 8;
	localparam int DEPTH_DEF = 16;

	// fixed field widths
	localparam int DATA_W = 32;
	localparam int IDX_W  = 3;

	// operation codes on the input tuser
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// control from the sequencer to the shared comparator
	typedef struct packed {
		logic clear;
		logic cand;
	} best_ctl_t;

endpackage

FILE: design/kwm_mem.sv
// entry store for all ways: one write port, one registered read port
`timescale 1ns / 1ps

module kwm_mem #(
	parameter int AW = 7
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [kwm_pkg::DATA_W-1:0] wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [kwm_pkg::DATA_W-1:0] rdata
);

	localparam int ENTRIES = 1 << AW;

	logic [kwm_pkg::DATA_W-1:0] mem_q [ENTRIES];
	logic [kwm_pkg::DATA_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/kwm_best.sv
// shared signed comparator that keeps the smallest head seen during a scan
`timescale 1ns / 1ps

module kwm_best #(
	parameter int WAY_W = 3
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kwm_pkg::best_ctl_t         ctl,
	input  logic [kwm_pkg::DATA_W-1:0] cand_val,
	input  logic [WAY_W-1:0]           cand_way,
	output logic                       found,
	output logic [kwm_pkg::DATA_W-1:0] best_val,
	output logic [WAY_W-1:0]           best_way
);

	logic                       found_q;
	logic [kwm_pkg::DATA_W-1:0] best_val_q;
	logic [WAY_W-1:0]           best_way_q;
	logic                       take;

	// ties go to the later (higher) way
	assign take = ctl.cand && (!found_q || ($signed(cand_val) <= $signed(best_val_q)));

	// found flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (ctl.cand) begin
			found_q <= 1'b1;
		end
	end

	// best value and its way
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_val_q <= '0;
			best_way_q <= '0;
		end else if (take) begin
			best_val_q <= cand_val;
			best_way_q <= cand_way;
		end
	end

	assign found    = found_q;
	assign best_val = best_val_q;
	assign best_way = best_way_q;

	// a candidate always leaves a best entry behind
	a_cand_found: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.cand && !ctl.clear |=> found_q)
		else $error("candidate did not set found");

	// a taken candidate becomes the kept minimum
	a_take_val: assert property (@(posedge clk) disable iff (!arst_n)
		take && !ctl.clear |=> best_val_q == $past(cand_val))
		else $error("best value not updated");

endmodule

FILE: design/k_way_sorted_merge.sv
// top level of the k-way sorted merge engine: sequencer, way pointers, result register
//
// channel | direction | tdata                          | tuser
// s_*     | in        | list_index[2:0] value[34:3]    | func[0]
// m_*     | out       | merged_value[31:0]             | valid_res[0] status[2:1]
//
// a push goes through S_PUSH; a pop scans one head per way through the single memory
// read port and comparator, then passes S_DRAIN, S_LOAD and S_RESULT.
// reset clears all way pointers and fill counts; the entry store is not cleared.
// ready is high only while the sequencer is idle; a finished result waits in the
// output register; S_PUSH and S_RESULT wait until the master side takes that beat.
`timescale 1ns / 1ps

module k_way_sorted_merge #(
	parameter int WAYS  = kwm_pkg::WAYS_DEF,
	parameter int DEPTH = kwm_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // list_index[2:0], value[34:3], zero pad
	input  logic [0:0]  s_tuser,  // func[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // merged_value[31:0]
	output logic [2:0]  m_tuser   // valid_res[0], status[2:1]
);

	localparam int WAY_W = $clog2(WAYS);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int AW    = WAY_W + PTR_W;
	localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);
	localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH,
		S_SCAN,
		S_DRAIN,
		S_LOAD,
		S_RESULT
	} state_t;

	state_t                     state_q;
	logic [WAY_W-1:0]           idx_q;
	logic                       push_ok_q;
	logic [kwm_pkg::DATA_W-1:0] value_q;
	logic [PTR_W-1:0]           head_q [WAYS];
	logic [CNT_W-1:0]           cnt_q [WAYS];
	logic                       rd_valid_s1;
	logic [WAY_W-1:0]           rd_way_s1;
	logic                       m_tvalid_q;
	logic [31:0]                m_tdata_q;
	logic [2:0]                 m_tuser_q;

	logic [PTR_W-1:0]           head_sel;
	logic [CNT_W-1:0]           cnt_sel;
	logic [SUM_W-1:0]           tail_sum;
	logic [PTR_W-1:0]           tail_sel;
	logic [PTR_W:0]             head_inc;
	logic [PTR_W-1:0]           head_nxt;
	logic                       push_full;
	logic                       out_free;
	logic                       res_load;
	logic                       mem_we;
	logic                       mem_re;
	logic [kwm_pkg::DATA_W-1:0] mem_rdata;
	kwm_pkg::best_ctl_t         best_ctl;
	logic                       best_found;
	logic [kwm_pkg::DATA_W-1:0] best_val;
	logic [WAY_W-1:0]           best_way;

	// selected way pointers and wrap arithmetic
	assign head_sel  = head_q[idx_q];
	assign cnt_sel   = cnt_q[idx_q];
	assign tail_sum  = SUM_W'(head_sel) + SUM_W'(cnt_sel);
	assign tail_sel  = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
	                                               : PTR_W'(tail_sum);
	assign head_inc  = {1'b0, head_sel} + (PTR_W + 1)'(1);
	assign head_nxt  = (head_inc >= (PTR_W + 1)'(DEPTH)) ? '0 : head_inc[PTR_W-1:0];
	assign push_full = !push_ok_q || (cnt_sel == DEPTH_C);

	// handshake
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	// result register load
	assign res_load = ((state_q == S_PUSH) || (state_q == S_RESULT)) && out_free;

	// memory control
	assign mem_we = (state_q == S_PUSH) && out_free && !push_full;
	assign mem_re = (state_q == S_SCAN) && (cnt_sel != '0);

	// comparator control
	assign best_ctl.clear = s_tvalid && s_tready && (s_tuser[0] == kwm_pkg::FUNC_POP);
	assign best_ctl.cand  = rd_valid_s1;

	kwm_mem #(
		.AW(AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr ({idx_q, tail_sel}),
		.wdata (value_q),
		.re    (mem_re),
		.raddr ({idx_q, head_sel}),
		.rdata (mem_rdata)
	);

	kwm_best #(
		.WAY_W(WAY_W)
	) u_best (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (best_ctl),
		.cand_val (mem_rdata),
		.cand_way (rd_way_s1),
		.found    (best_found),
		.best_val (best_val),
		.best_way (best_way)
	);

	// input payload capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			value_q <= s_tdata[34:3];
		end
	end

	// sequencer, way pointers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			push_ok_q   <= 1'b0;
			rd_valid_s1 <= 1'b0;
			rd_way_s1   <= '0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			m_tuser_q   <= '0;
			for (int w = 0; w < WAYS; w++) begin
				head_q[w] <= '0;
				cnt_q[w]  <= '0;
			end
		end else begin
			rd_valid_s1 <= mem_re;
			rd_way_s1   <= idx_q;
			if (res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser[0] == kwm_pkg::FUNC_POP) begin
							idx_q   <= '0;
							state_q <= S_SCAN;
						end else begin
							idx_q     <= WAY_W'(s_tdata[2:0]);
							push_ok_q <= (int'(s_tdata[2:0]) < WAYS);
							state_q   <= S_PUSH;
						end
					end
				end
				S_PUSH: begin
					if (out_free) begin
						m_tdata_q  <= '0;
						if (push_full) begin
							m_tuser_q <= {kwm_pkg::ST_FULL, 1'b0};
						end else begin
							cnt_q[idx_q] <= cnt_sel + CNT_W'(1);
							m_tuser_q    <= {kwm_pkg::ST_OK, 1'b0};
						end
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (idx_q == LAST_WAY) begin
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + WAY_W'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					idx_q   <= best_way;
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free) begin
						if (best_found) begin
							head_q[idx_q] <= head_nxt;
							cnt_q[idx_q]  <= cnt_sel - CNT_W'(1);
							m_tdata_q     <= best_val;
							m_tuser_q     <= {kwm_pkg::ST_OK, 1'b1};
						end else begin
							m_tdata_q <= '0;
							m_tuser_q <= {kwm_pkg::ST_EMPTY, 1'b0};
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// the selected way never holds more than its depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_sel <= DEPTH_C)
		else $error("fill count above depth");

	// a popped value always carries ok status
	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tuser[2:1] == kwm_pkg::ST_OK)
		else $error("valid result with error status");

	// no value on a beat without valid_res
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("data on a beat without a popped value");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item accepted while busy");

endmodule

FILE: verif/tb_top.sv
// testbench for the k-way sorted merge engine: stream drivers, merge predictor, scoreboard
`timescale 1ns / 1ps

module tb_top;

	localparam int N_WAYS     = kwm_pkg::WAYS_DEF;
	localparam int N_DEPTH    = kwm_pkg::DEPTH_DEF;
	localparam int D_W        = kwm_pkg::DATA_W;
	localparam int I_W        = kwm_pkg::IDX_W;
	localparam int CYCLE_CAP  = 400000;
	localparam int N_RANDOM   = 700;

	// one result beat as the block should produce it
	typedef struct {
		logic signed [D_W-1:0] merged;
		logic                  valid;
		kwm_pkg::status_t      st;
	} merge_beat_t;

	// predicts the merge engine and checks its result beats in order
	class merge_scoreboard;
		logic signed [D_W-1:0] lane_mem [N_WAYS][N_DEPTH];
		int unsigned rd_ptr [N_WAYS];
		int unsigned wr_ptr [N_WAYS];
		int unsigned held [N_WAYS];
		merge_beat_t pending_beats [$];
		int n_errors;
		int n_checked;
		int n_push;
		int n_drop;
		int n_pop;
		int n_empty;
		int n_tie;

		function new();
			for (int i = 0; i < N_WAYS; i++) begin
				rd_ptr[i] = 0;
				wr_ptr[i] = 0;
				held[i]   = 0;
			end
			n_errors = 0;
			n_checked = 0;
			n_push = 0;
			n_drop = 0;
			n_pop = 0;
			n_empty = 0;
			n_tie = 0;
		endfunction

		function int unsigned next_slot(int unsigned p);
			return (p + 1 >= N_DEPTH) ? 0 : p + 1;
		endfunction

		function int total_held();
			int sum;
			sum = 0;
			for (int i = 0; i < N_WAYS; i++)
				sum += held[i];
			return sum;
		endfunction

		function int pending();
			return pending_beats.size();
		endfunction

		// apply one accepted request and queue the beat it must produce
		function void note_request(logic func, logic [I_W-1:0] way,
				logic signed [D_W-1:0] val);
			merge_beat_t r;
			int best;
			r.merged = '0;
			r.valid  = 1'b0;
			r.st     = kwm_pkg::ST_OK;
			if (func == kwm_pkg::FUNC_PUSH) begin
				if (way >= N_WAYS || held[way] >= N_DEPTH) begin
					r.st = kwm_pkg::ST_FULL;
					n_drop++;
				end else begin
					lane_mem[way][wr_ptr[way]] = val;
					wr_ptr[way] = next_slot(wr_ptr[way]);
					held[way]++;
					n_push++;
				end
			end else begin
				best = -1;
				// lowest head wins, higher way on equal heads
				for (int i = 0; i < N_WAYS; i++) begin
					if (held[i] != 0) begin
						if (best < 0) begin
							best = i;
						end else if (lane_mem[i][rd_ptr[i]] <= lane_mem[best][rd_ptr[best]]) begin
							if (lane_mem[i][rd_ptr[i]] == lane_mem[best][rd_ptr[best]])
								n_tie++;
							best = i;
						end
					end
				end
				if (best < 0) begin
					r.st = kwm_pkg::ST_EMPTY;
					n_empty++;
				end else begin
					r.merged = lane_mem[best][rd_ptr[best]];
					r.valid  = 1'b1;
					rd_ptr[best] = next_slot(rd_ptr[best]);
					held[best]--;
					n_pop++;
				end
			end
			pending_beats = {pending_beats, r};
		endfunction

		// compare one result beat with the oldest pending one
		function void check_beat(logic signed [D_W-1:0] got_val, logic got_valid,
				logic [1:0] got_st);
			merge_beat_t w;
			n_checked++;
			if (pending_beats.size() == 0) begin
				$display("%0t: result beat with none pending: value %0d valid %0b status %0d",
					$time, got_val, got_valid, got_st);
				n_errors++;
				return;
			end
			w = pending_beats.pop_front();
			if (got_val !== w.merged) begin
				$display("%0t: merged_value mismatch: expected %0d, got %0d",
					$time, w.merged, got_val);
				n_errors++;
			end
			if (got_valid !== w.valid) begin
				$display("%0t: valid_res mismatch: expected %0b, got %0b",
					$time, w.valid, got_valid);
				n_errors++;
			end
			if (got_st !== w.st) begin
				$display("%0t: status mismatch: expected %0d, got %0d",
					$time, w.st, got_st);
				n_errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;

	merge_scoreboard sb = new();
	bit   quiet_phase = 1'b0;
	bit   long_hold_done = 1'b0;
	int   cycle_count = 0;
	int   items_sent = 0;

	k_way_sorted_merge dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// clock and cycle cap
	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("%0t: timeout with %0d beats pending", $time, sb.pending());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one, none in quiet phases
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_phase || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result side: random back-pressure plus one long hold to fill the block
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!long_hold_done && sb.n_checked >= 150) begin
				long_hold_done = 1'b1;
				hold_left = 400;
				m_tready <= 1'b0;
			end else if (!quiet_phase && $urandom_range(0, 99) < 25) begin
				hold_left = pick_gap();
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// check every accepted result beat
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_beat(m_tdata, m_tuser[0], m_tuser[2:1]);
	end

	// offer one request beat and wait until it is taken
	task automatic send_item(logic func, logic [I_W-1:0] way, logic signed [D_W-1:0] val);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, val, way};
		s_tuser  <= func;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_request(func, way, val);
		items_sent++;
	endtask

	task automatic send_pop();
		send_item(kwm_pkg::FUNC_POP, I_W'($urandom), D_W'($urandom));
	endtask

	// ascending lists into a window of ways, then drain them
	task automatic sorted_lists();
		logic signed [D_W-1:0] tail_val [N_WAYS];
		int lo, hi, npush, step, way, ndrain;
		lo = $urandom_range(0, N_WAYS - 1);
		hi = $urandom_range(lo, N_WAYS - 1);
		npush = $urandom_range(4, 50);
		case ($urandom_range(0, 3))
			0: step = 0;
			1: step = 3;
			2: step = 1000;
			default: step = 1 << 24;
		endcase
		for (int i = 0; i < N_WAYS; i++)
			tail_val[i] = (step == 0) ? D_W'($urandom_range(0, 2)) : D_W'($urandom);
		for (int k = 0; k < npush; k++) begin
			way = $urandom_range(lo, hi);
			tail_val[way] = tail_val[way] + $urandom_range(0, step);
			send_item(kwm_pkg::FUNC_PUSH, I_W'(way), tail_val[way]);
		end
		ndrain = sb.total_held() + $urandom_range(0, 2);
		repeat (ndrain) send_pop();
	endtask

	// overfill a single way
	task automatic overfill_way();
		int way, val;
		way = $urandom_range(0, N_WAYS - 1);
		val = $urandom_range(0, 100) - 50;
		repeat (N_DEPTH + $urandom_range(1, 3) - sb.held[way]) begin
			send_item(kwm_pkg::FUNC_PUSH, I_W'(way), val);
			val += $urandom_range(0, 5);
		end
		repeat ($urandom_range(1, N_DEPTH)) send_pop();
	endtask

	// random mix of pushes and pops, wide or narrow values
	task automatic mixed_noise(bit narrow);
		logic signed [D_W-1:0] val;
		repeat ($urandom_range(20, 60)) begin
			if (narrow)
				val = D_W'($urandom_range(0, 4)) - 2;
			else if ($urandom_range(0, 9) == 0)
				val = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
			else
				val = D_W'($urandom);
			if ($urandom_range(0, 1))
				send_item(kwm_pkg::FUNC_PUSH, I_W'($urandom), val);
			else
				send_pop();
		end
	endtask

	// main sequence
	initial begin
		int kind;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty pop, extremes, unsorted way, equal heads, ignored pop fields
		send_item(kwm_pkg::FUNC_POP, '0, '0);
		send_item(kwm_pkg::FUNC_PUSH, 3'd0, 32'sh8000_0000);
		send_item(kwm_pkg::FUNC_PUSH, 3'd7, 32'sh7fff_ffff);
		send_item(kwm_pkg::FUNC_PUSH, 3'd3, 32'sd0);
		send_item(kwm_pkg::FUNC_PUSH, 3'd3, -32'sd1);
		send_item(kwm_pkg::FUNC_PUSH, 3'd1, 32'sd42);
		send_item(kwm_pkg::FUNC_PUSH, 3'd6, 32'sd42);
		send_item(kwm_pkg::FUNC_PUSH, 3'd4, 32'sh5555_5555);
		send_item(kwm_pkg::FUNC_PUSH, 3'd2, 32'shaaaa_aaaa);
		send_item(kwm_pkg::FUNC_POP, 3'd7, 32'shffff_ffff);
		repeat (7) send_item(kwm_pkg::FUNC_POP, '0, '0);
		send_item(kwm_pkg::FUNC_POP, 3'd5, 32'sh1234_5678);

		// random phases
		while (items_sent < N_RANDOM) begin
			quiet_phase = ($urandom_range(0, 5) == 0);
			kind = $urandom_range(0, 9);
			if (kind < 5)
				sorted_lists();
			else if (kind < 7)
				overfill_way();
			else if (kind < 9)
				mixed_noise(1'b0);
			else
				mixed_noise(1'b1);
		end
		quiet_phase = 1'b0;

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4 * N_WAYS) @(posedge clk);

		$display("covered %0d requests: %0d pushes kept, %0d dropped on a full way,",
			items_sent, sb.n_push, sb.n_drop);
		$display("%0d values popped (%0d equal-head picks), %0d pops with all ways empty",
			sb.n_pop, sb.n_tie, sb.n_empty);
		if (sb.n_errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: k_way_sorted_merge.f
design/kwm_pkg.sv
design/kwm_mem.sv
design/kwm_best.sv
design/k_way_sorted_merge.sv
verif/tb_top.sv
